### src/wsfr_pkg.sv
// Shared types and constants for the WebSocket frame receiver.
package wsfr_pkg;

    // Frame opcodes
    localparam logic [3:0] OP_CONT   = 4'h0;
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;
    localparam logic [3:0] OP_PONG   = 4'hA;

    // Length field codes and header byte counts
    localparam logic [6:0] LEN_EXT16    = 7'd126;
    localparam logic [6:0] LEN_EXT64    = 7'd127;
    localparam int         CTRL_MAX_LEN = 125;
    localparam logic [3:0] EXT16_BYTES  = 4'd2;
    localparam logic [3:0] EXT64_BYTES  = 4'd8;
    localparam logic [3:0] KEY_BYTES    = 4'd4;

    // Result queue depth and output bus width
    localparam int QDEPTH  = 2;
    localparam int TDATA_W = 24;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_COMPRESSION = 1'b0,
        CFG_MAX_LEN     = 1'b1
    } cfg_index_t;

    // Result status codes
    typedef enum logic [3:0] {
        ST_OK           = 4'd0,
        ST_RSV23        = 4'd1,
        ST_RSV1_NOCOMP  = 4'd2,
        ST_RSV1_CONT    = 4'd3,
        ST_ORPHAN_CONT  = 4'd4,
        ST_DATA_IN_FRAG = 4'd5,
        ST_CTRL_FRAG    = 4'd6,
        ST_CTRL_LONG    = 4'd7,
        ST_BAD_OPCODE   = 4'd8,
        ST_TOO_LONG     = 4'd9
    } status_t;

    // One classified request passed from the parser to the output stage
    typedef struct packed {
        logic [7:0] raw;
        logic [7:0] key;
        logic       byte_valid;
        logic [3:0] opcode;
        logic       is_control;
        logic       compressed;
        logic       frame_end;
        logic       message_end;
        status_t    status;
    } wsfr_entry_t;

endpackage

### src/wsfr_front.sv
// Header parser and classifier: turns stream bytes into result requests.
module wsfr_front #(
    parameter int LENGTH_BITS = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic                 kind,
    input  logic [7:0]           byte_in,
    input  logic                 compression_enabled,
    input  logic [31:0]          max_payload_length,
    output logic                 push,
    output wsfr_pkg::wsfr_entry_t entry
);
    import wsfr_pkg::*;

    localparam int CmpW   = (LENGTH_BITS > 32) ? LENGTH_BITS : 32;
    localparam bit CanSat = (LENGTH_BITS < 64);

    typedef enum logic [2:0] {
        PH_HDR1    = 3'd0,
        PH_HDR2    = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_MASKKEY = 3'd3,
        PH_PAYLOAD = 3'd4
    } phase_t;

    phase_t                  phase_reg, phase_next;
    logic [3:0]              ext_reg, ext_next;
    logic [7:0]              fhb_reg, fhb_next;
    logic                    masked_reg, masked_next;
    logic [31:0]             key_reg, key_next;
    logic [1:0]              mpos_reg, mpos_next;
    logic [LENGTH_BITS-1:0]  rem_reg, rem_next;
    logic                    sat_reg, sat_next;
    logic                    frag_reg, frag_next;
    logic [3:0]              msg_op_reg, msg_op_next;
    logic                    msg_comp_reg, msg_comp_next;
    logic                    err_reg, err_next;

    logic                    done;
    logic [LENGTH_BITS-1:0]  len_sel;
    logic                    sat_sel;
    status_t                 st;
    logic [7:0]              key_byte;
    logic                    ctrl;

    // Check a completed header, codes in priority order
    function automatic status_t hdr_status(
        input logic [7:0]             fhb,
        input logic [LENGTH_BITS-1:0] len,
        input logic                   sat,
        input logic                   frag,
        input logic                   comp_en,
        input logic [31:0]            max_len
    );
        status_t    s;
        logic [3:0] op;
        logic       over_ctrl;
        logic       over_max;
        s         = ST_OK;
        op        = fhb[3:0];
        over_ctrl = sat || (len > LENGTH_BITS'(CTRL_MAX_LEN));
        over_max  = sat || (CmpW'(len) > CmpW'(max_len));
        priority if (fhb[5] || fhb[4])
            s = ST_RSV23;
        else if (fhb[6] && !comp_en)
            s = ST_RSV1_NOCOMP;
        else if (op == OP_CONT && frag && fhb[6])
            s = ST_RSV1_CONT;
        else if (op == OP_CONT)
        begin
            if (!frag)
                s = ST_ORPHAN_CONT;
        end
        else if (op == OP_TEXT || op == OP_BINARY)
        begin
            if (frag)
                s = ST_DATA_IN_FRAG;
        end
        else if (op == OP_CLOSE || op == OP_PING || op == OP_PONG)
        begin
            if (!fhb[7])
                s = ST_CTRL_FRAG;
            else if (over_ctrl)
                s = ST_CTRL_LONG;
        end
        else
            s = ST_BAD_OPCODE;
        if (s == ST_OK && over_max)
            s = ST_TOO_LONG;
        return s;
    endfunction

    // Parse one stream byte and form its result request
    always_comb
    begin
        phase_next    = phase_reg;
        ext_next      = ext_reg;
        fhb_next      = fhb_reg;
        masked_next   = masked_reg;
        key_next      = key_reg;
        mpos_next     = mpos_reg;
        rem_next      = rem_reg;
        sat_next      = sat_reg;
        frag_next     = frag_reg;
        msg_op_next   = msg_op_reg;
        msg_comp_next = msg_comp_reg;
        err_next      = err_reg;
        push          = 1'b0;
        entry         = '0;
        done          = 1'b0;
        len_sel       = rem_reg;
        sat_sel       = sat_reg;
        st            = ST_OK;
        key_byte      = '0;
        ctrl          = fhb_reg[3];

        if (accept)
        begin
            if (kind)
            begin
                // Connection reset: drop all parse, fragment and error state
                phase_next    = PH_HDR1;
                ext_next      = '0;
                fhb_next      = '0;
                masked_next   = 1'b0;
                key_next      = '0;
                mpos_next     = '0;
                rem_next      = '0;
                sat_next      = 1'b0;
                frag_next     = 1'b0;
                msg_op_next   = '0;
                msg_comp_next = 1'b0;
                err_next      = 1'b0;
            end
            else if (!err_reg)
            begin
                unique case (phase_reg)
                    PH_HDR2:
                    begin
                        masked_next = byte_in[7];
                        key_next    = '0;
                        mpos_next   = '0;
                        sat_next    = 1'b0;
                        if (byte_in[6:0] == LEN_EXT16 || byte_in[6:0] == LEN_EXT64)
                        begin
                            ext_next   = (byte_in[6:0] == LEN_EXT16) ? EXT16_BYTES
                                                                     : EXT64_BYTES;
                            rem_next   = '0;
                            phase_next = PH_EXTLEN;
                        end
                        else
                        begin
                            rem_next = LENGTH_BITS'(byte_in[6:0]);
                            if (byte_in[7])
                            begin
                                ext_next   = KEY_BYTES;
                                phase_next = PH_MASKKEY;
                            end
                            else
                            begin
                                done    = 1'b1;
                                len_sel = rem_next;
                                sat_sel = 1'b0;
                            end
                        end
                    end
                    PH_EXTLEN:
                    begin
                        // Shift in a length byte, saturate once it cannot fit
                        if (CanSat && (rem_reg[LENGTH_BITS-1 -: 8] != 8'd0))
                        begin
                            rem_next = '1;
                            sat_next = 1'b1;
                        end
                        else
                            rem_next = {rem_reg[LENGTH_BITS-9:0], byte_in};
                        ext_next = ext_reg - 4'd1;
                        if (ext_reg == 4'd1)
                        begin
                            if (masked_reg)
                            begin
                                ext_next   = KEY_BYTES;
                                phase_next = PH_MASKKEY;
                            end
                            else
                            begin
                                done    = 1'b1;
                                len_sel = rem_next;
                                sat_sel = sat_next;
                            end
                        end
                    end
                    PH_MASKKEY:
                    begin
                        key_next = {key_reg[23:0], byte_in};
                        ext_next = ext_reg - 4'd1;
                        if (ext_reg == 4'd1)
                            done = 1'b1;
                    end
                    PH_PAYLOAD:
                    begin
                        // Pick the key byte, most significant first
                        unique case (mpos_reg)
                            2'd0:    key_byte = key_reg[31:24];
                            2'd1:    key_byte = key_reg[23:16];
                            2'd2:    key_byte = key_reg[15:8];
                            default: key_byte = key_reg[7:0];
                        endcase
                        mpos_next         = mpos_reg + 2'd1;
                        rem_next          = rem_reg - LENGTH_BITS'(1);
                        push              = 1'b1;
                        entry.raw         = byte_in;
                        entry.key         = key_byte;
                        entry.byte_valid  = 1'b1;
                        entry.opcode      = ctrl ? fhb_reg[3:0] : msg_op_reg;
                        entry.is_control  = ctrl;
                        entry.compressed  = ctrl ? 1'b0 : msg_comp_reg;
                        entry.frame_end   = (rem_reg == LENGTH_BITS'(1));
                        entry.message_end = (rem_reg == LENGTH_BITS'(1))
                                            && fhb_reg[7] && !ctrl;
                        if (rem_reg == LENGTH_BITS'(1))
                            phase_next = PH_HDR1;
                    end
                    default:
                    begin
                        fhb_next   = byte_in;
                        phase_next = PH_HDR2;
                    end
                endcase

                // Header done: reject, else update message, payload or marker
                if (done)
                begin
                    st = hdr_status(fhb_reg, len_sel, sat_sel, frag_reg,
                                    compression_enabled, max_payload_length);
                    if (st != ST_OK)
                    begin
                        push         = 1'b1;
                        entry.opcode = fhb_reg[3:0];
                        entry.status = st;
                        err_next     = 1'b1;
                        phase_next   = PH_HDR1;
                    end
                    else
                    begin
                        if (fhb_reg[3:0] == OP_TEXT || fhb_reg[3:0] == OP_BINARY)
                        begin
                            msg_op_next   = fhb_reg[3:0];
                            msg_comp_next = fhb_reg[6];
                            frag_next     = !fhb_reg[7];
                        end
                        else if (fhb_reg[3:0] == OP_CONT)
                            frag_next = !fhb_reg[7];
                        mpos_next = '0;
                        if (len_sel == '0)
                        begin
                            push              = 1'b1;
                            entry.opcode      = ctrl ? fhb_reg[3:0] : msg_op_next;
                            entry.is_control  = ctrl;
                            entry.compressed  = ctrl ? 1'b0 : msg_comp_next;
                            entry.frame_end   = 1'b1;
                            entry.message_end = fhb_reg[7] && !ctrl;
                            phase_next        = PH_HDR1;
                        end
                        else
                            phase_next = PH_PAYLOAD;
                    end
                end
            end
        end
    end

    // Hold parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HDR1;
            ext_reg      <= '0;
            fhb_reg      <= '0;
            masked_reg   <= 1'b0;
            key_reg      <= '0;
            mpos_reg     <= '0;
            rem_reg      <= '0;
            sat_reg      <= 1'b0;
            frag_reg     <= 1'b0;
            msg_op_reg   <= '0;
            msg_comp_reg <= 1'b0;
            err_reg      <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            ext_reg      <= ext_next;
            fhb_reg      <= fhb_next;
            masked_reg   <= masked_next;
            key_reg      <= key_next;
            mpos_reg     <= mpos_next;
            rem_reg      <= rem_next;
            sat_reg      <= sat_next;
            frag_reg     <= frag_next;
            msg_op_reg   <= msg_op_next;
            msg_comp_reg <= msg_comp_next;
            err_reg      <= err_next;
        end
    end

`ifndef SYNTHESIS
    a_ext_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_EXTLEN || phase_reg == PH_MASKKEY) |-> ext_reg != 4'd0)
        else $error("header byte count ran out inside header");
    a_payload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD |-> rem_reg != '0)
        else $error("payload phase with nothing left");
    a_error_latches: assert property (@(posedge clk) disable iff (!rst_n)
        (push && entry.status != ST_OK) |=> err_reg)
        else $error("header error did not latch");
`endif

endmodule

### src/wsfr_queue.sv
// Two-entry request queue between the parser and the output stage.
module wsfr_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  wsfr_pkg::wsfr_entry_t push_entry,
    input  logic                  pop,
    output wsfr_pkg::wsfr_entry_t head,
    output logic                  full,
    output logic                  empty
);
    import wsfr_pkg::*;

    localparam int PtrW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CntW = $clog2(QDEPTH + 1);

    wsfr_entry_t     slot_reg [QDEPTH];
    logic [PtrW-1:0] wr_reg, wr_next;
    logic [PtrW-1:0] rd_reg, rd_next;
    logic [CntW-1:0] count_reg, count_next;

    assign full  = (count_reg == CntW'(QDEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_next    = wr_reg;
        rd_next    = rd_reg;
        count_next = count_reg;
        if (push)
            wr_next = (wr_reg == PtrW'(QDEPTH - 1)) ? '0 : wr_reg + PtrW'(1);
        if (pop)
            rd_next = (rd_reg == PtrW'(QDEPTH - 1)) ? '0 : rd_reg + PtrW'(1);
        if (push && !pop)
            count_next = count_reg + CntW'(1);
        else if (pop && !push)
            count_next = count_reg - CntW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    // Store incoming requests
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_reg] <= push_entry;
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("request pushed into full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("request popped from empty queue");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CntW'(QDEPTH))
        else $error("queue occupancy beyond depth");
`endif

endmodule

### src/wsfr_back.sv
// Output stage: unmasks payload and holds the result for the master side.
module wsfr_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  wsfr_pkg::wsfr_entry_t         head,
    input  logic                          empty,
    output logic                          pop,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [wsfr_pkg::TDATA_W-1:0]  m_axis_tdata,
    output logic                          m_axis_tlast,
    output logic                          m_axis_tuser
);
    import wsfr_pkg::*;

    logic               valid_reg;
    logic [TDATA_W-1:0] data_reg, data_next;
    logic               last_reg;
    logic               user_reg;
    logic [7:0]         payload;

    // Take the next request whenever the output register is free or being taken
    assign pop = !empty && (!valid_reg || m_axis_tready);

    // Unmask and pack: payload, opcode, control, compressed, message end, status
    always_comb
    begin
        payload   = head.byte_valid ? (head.raw ^ head.key) : 8'd0;
        data_next = TDATA_W'({head.status, head.message_end, head.compressed,
                              head.is_control, head.opcode, payload});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (pop)
            valid_reg <= 1'b1;
        else if (m_axis_tready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            data_reg <= data_next;
            last_reg <= head.frame_end;
            user_reg <= head.byte_valid;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = data_reg;
    assign m_axis_tlast  = last_reg;
    assign m_axis_tuser  = user_reg;

endmodule

### src/websocket_frame_receiver.sv
// A payload, marker or error result is held in the request queue, then the output register.
// One byte per clock while s_axis_tready is high; no header byte but the last gives a result.
// s_axis_tready drops only when both entries of the parser-to-output queue are occupied.
// rst_n clears parser, fragment and error state and sets registers to their defaults
// (compression off, maximum payload 16777216 bytes); tuser=1 on s_axis clears all but registers.
// Top level: configuration registers, stream parser, request queue and output stage.
module websocket_frame_receiver #(
    parameter int LENGTH_BITS = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // Configuration writes
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic                         cfg_index,
    input  logic [31:0]                  cfg_data,
    // Received stream
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [7:0]                   s_axis_tdata,  // [7:0] stream_byte
    input  logic                         s_axis_tuser,  // [0] kind
    // Results
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // [7:0] payload_byte, [11:8] frame_opcode, [12] is_control, [13] compressed,
    // [14] message_end, [18:15] status, [23:19] zero
    output logic [wsfr_pkg::TDATA_W-1:0] m_axis_tdata,
    output logic                         m_axis_tlast,  // frame_end
    output logic                         m_axis_tuser   // [0] byte_valid
);
    import wsfr_pkg::*;

    logic        compression_enabled_reg;
    logic [31:0] max_payload_length_reg;
    logic        accept;
    logic        push;
    logic        pop;
    logic        full;
    logic        empty;
    wsfr_entry_t push_entry;
    wsfr_entry_t head;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            compression_enabled_reg <= 1'b0;
            max_payload_length_reg  <= 32'd16777216;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_COMPRESSION: compression_enabled_reg <= cfg_data[0];
                CFG_MAX_LEN:     max_payload_length_reg  <= cfg_data;
                default:         max_payload_length_reg  <= max_payload_length_reg;
            endcase
        end
    end

    wsfr_front #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_front (
        .clk                (clk),
        .rst_n              (rst_n),
        .accept             (accept),
        .kind               (s_axis_tuser),
        .byte_in            (s_axis_tdata),
        .compression_enabled(compression_enabled_reg),
        .max_payload_length (max_payload_length_reg),
        .push               (push),
        .entry              (push_entry)
    );

    wsfr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_entry(push_entry),
        .pop       (pop),
        .head      (head),
        .full      (full),
        .empty     (empty)
    );

    wsfr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .empty        (empty),
        .pop          (pop),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .m_axis_tuser (m_axis_tuser)
    );

endmodule

### tb/sv/websocket_frame_receiver_checker.sv
`timescale 1ns / 1ps
// Result checker for the WebSocket frame receiver: predicts each result and compares it.
module websocket_frame_receiver_checker #(
    parameter int LENGTH_BITS = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    input  logic                         cfg_ready,
    input  logic                         cfg_index,
    input  logic [31:0]                  cfg_data,
    input  logic                         s_axis_tvalid,
    input  logic                         s_axis_tready,
    input  logic [7:0]                   s_axis_tdata,
    input  logic                         s_axis_tuser,
    input  logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    input  logic [wsfr_pkg::TDATA_W-1:0] m_axis_tdata,
    input  logic                         m_axis_tlast,
    input  logic                         m_axis_tuser,
    output int                           failures,
    output int                           results_awaited,
    output int                           payload_seen,
    output int                           markers_seen,
    output int                           rejects_seen
);
    import wsfr_pkg::*;

    localparam int PRINT_CAP = 40;

    typedef enum logic [2:0] {
        WAIT_B0,
        WAIT_B1,
        EXT_LEN,
        KEY_LOAD,
        PAYLOAD
    } parse_phase_t;

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic [3:0] opcode;
        logic       ctrl;
        logic       comp;
        logic       fend;
        logic       mend;
        status_t    status;
    } frame_result_t;

    // Mirror of the configuration registers
    logic         comp_en;
    logic [31:0]  max_len;

    // Mirror of the parser and fragment state
    parse_phase_t phase;
    logic [3:0]   hdr_left;
    logic [7:0]   hdr0;
    logic         masked;
    logic [31:0]  key_word;
    logic [1:0]   key_pos;
    logic [63:0]  remaining;
    logic         in_frag;
    logic [3:0]   msg_op;
    logic         msg_comp;
    logic         locked;

    frame_result_t awaited_results[$];

    initial begin
        failures        = 0;
        results_awaited = 0;
        payload_seen    = 0;
        markers_seen    = 0;
        rejects_seen    = 0;
    end

    task automatic report_mismatch(input string what);
        failures++;
        if (failures <= PRINT_CAP)
            $display("%0t checker: %s", $time, what);
    endtask

    function automatic void clear_parser();
        phase     = WAIT_B0;
        hdr_left  = '0;
        hdr0      = '0;
        masked    = 1'b0;
        key_word  = '0;
        key_pos   = '0;
        remaining = '0;
        in_frag   = 1'b0;
        msg_op    = OP_CONT;
        msg_comp  = 1'b0;
        locked    = 1'b0;
    endfunction

    function automatic frame_result_t pack_result(input logic [7:0] d, input logic v,
                                                  input logic [3:0] opc, input logic ctrl,
                                                  input logic comp, input logic fe,
                                                  input logic me, input status_t st);
        frame_result_t r;
        r.data   = d;
        r.valid  = v;
        r.opcode = opc;
        r.ctrl   = ctrl;
        r.comp   = comp;
        r.fend   = fe;
        r.mend   = me;
        r.status = st;
        return r;
    endfunction

    // Header checks, in order of the status codes
    function automatic status_t header_verdict();
        logic       fin;
        logic       rsv1;
        logic [3:0] op;
        fin  = hdr0[7];
        rsv1 = hdr0[6];
        op   = hdr0[3:0];
        if (hdr0[5:4] != 2'b00) return ST_RSV23;
        if (rsv1 && !comp_en) return ST_RSV1_NOCOMP;
        if (op == OP_CONT && in_frag && rsv1) return ST_RSV1_CONT;
        if (op == OP_CONT) begin
            if (!in_frag) return ST_ORPHAN_CONT;
        end else if (op == OP_TEXT || op == OP_BINARY) begin
            if (in_frag) return ST_DATA_IN_FRAG;
        end else if (op == OP_CLOSE || op == OP_PING || op == OP_PONG) begin
            if (!fin) return ST_CTRL_FRAG;
            if (remaining > CTRL_MAX_LEN) return ST_CTRL_LONG;
        end else begin
            return ST_BAD_OPCODE;
        end
        if (remaining > {32'd0, max_len}) return ST_TOO_LONG;
        return ST_OK;
    endfunction

    // Control frames carry their own opcode; data frames carry the message's
    function automatic void frame_tags(output logic [3:0] opc, output logic ctrl,
                                       output logic comp);
        if (hdr0[3]) begin
            opc  = hdr0[3:0];
            ctrl = 1'b1;
            comp = 1'b0;
        end else begin
            opc  = msg_op;
            ctrl = 1'b0;
            comp = msg_comp;
        end
    endfunction

    function automatic void close_header(output logic got, output frame_result_t r);
        status_t    st;
        logic [3:0] op;
        logic [3:0] opc;
        logic       fin;
        logic       ctrl;
        logic       comp;
        st  = header_verdict();
        op  = hdr0[3:0];
        fin = hdr0[7];
        got = 1'b1;
        r   = '0;
        if (st != ST_OK) begin
            r      = pack_result(8'd0, 1'b0, op, 1'b0, 1'b0, 1'b0, 1'b0, st);
            locked = 1'b1;
            phase  = WAIT_B0;
            return;
        end
        if (op == OP_TEXT || op == OP_BINARY) begin
            msg_op   = op;
            msg_comp = hdr0[6];
            in_frag  = !fin;
        end else if (op == OP_CONT) begin
            in_frag = !fin;
        end
        key_pos = '0;
        if (remaining == 64'd0) begin
            frame_tags(opc, ctrl, comp);
            r     = pack_result(8'd0, 1'b0, opc, ctrl, comp, 1'b1, fin & !ctrl, ST_OK);
            phase = WAIT_B0;
            return;
        end
        got   = 1'b0;
        phase = PAYLOAD;
    endfunction

    // Advance the parser by one request and work out the result it causes
    function automatic void advance_parser(input logic conn_reset, input logic [7:0] b,
                                           output logic got, output frame_result_t r);
        logic [7:0] key;
        logic [3:0] opc;
        logic       ctrl;
        logic       comp;
        logic       fin;
        got = 1'b0;
        r   = '0;
        if (conn_reset) begin
            clear_parser();
            return;
        end
        if (locked) return;
        case (phase)
            WAIT_B1: begin
                masked   = b[7];
                key_word = '0;
                key_pos  = '0;
                if (b[6:0] == LEN_EXT16 || b[6:0] == LEN_EXT64) begin
                    hdr_left  = (b[6:0] == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
                    remaining = '0;
                    phase     = EXT_LEN;
                end else begin
                    remaining = {57'd0, b[6:0]};
                    if (masked) begin
                        hdr_left = KEY_BYTES;
                        phase    = KEY_LOAD;
                    end else begin
                        close_header(got, r);
                    end
                end
            end
            EXT_LEN: begin
                if (LENGTH_BITS < 64 && (remaining >> (LENGTH_BITS - 8)) != 64'd0)
                    remaining = '1;
                else
                    remaining = {remaining[55:0], b};
                hdr_left = hdr_left - 4'd1;
                if (hdr_left == 4'd0) begin
                    if (masked) begin
                        hdr_left = KEY_BYTES;
                        phase    = KEY_LOAD;
                    end else begin
                        close_header(got, r);
                    end
                end
            end
            KEY_LOAD: begin
                key_word = {key_word[23:0], b};
                hdr_left = hdr_left - 4'd1;
                if (hdr_left == 4'd0) close_header(got, r);
            end
            PAYLOAD: begin
                key       = key_word[(24 - 8 * int'(key_pos)) +: 8];
                key_pos   = key_pos + 2'd1;
                remaining = remaining - 64'd1;
                frame_tags(opc, ctrl, comp);
                fin = hdr0[7];
                got = 1'b1;
                if (remaining == 64'd0) begin
                    phase = WAIT_B0;
                    r = pack_result(b ^ key, 1'b1, opc, ctrl, comp, 1'b1, fin & !ctrl, ST_OK);
                end else begin
                    r = pack_result(b ^ key, 1'b1, opc, ctrl, comp, 1'b0, 1'b0, ST_OK);
                end
            end
            default: begin
                hdr0  = b;
                phase = WAIT_B1;
            end
        endcase
    endfunction

    // Compare accepted results, then predict from accepted requests
    always @(posedge clk) begin
        logic          got;
        frame_result_t r;
        frame_result_t want;
        string         diff;
        if (!rst_n) begin
            comp_en = 1'b0;
            max_len = 32'd16777216;
            clear_parser();
            awaited_results.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result, tdata %h tlast %b tuser %b",
                                              m_axis_tdata, m_axis_tlast, m_axis_tuser));
                end else begin
                    want = awaited_results.pop_front();
                    diff = "";
                    if (m_axis_tdata[7:0] != want.data)    diff = {diff, " payload_byte"};
                    if (m_axis_tuser != want.valid)        diff = {diff, " byte_valid"};
                    if (m_axis_tdata[11:8] != want.opcode) diff = {diff, " frame_opcode"};
                    if (m_axis_tdata[12] != want.ctrl)     diff = {diff, " is_control"};
                    if (m_axis_tdata[13] != want.comp)     diff = {diff, " compressed"};
                    if (m_axis_tlast != want.fend)         diff = {diff, " frame_end"};
                    if (m_axis_tdata[14] != want.mend)     diff = {diff, " message_end"};
                    if (m_axis_tdata[18:15] != want.status) diff = {diff, " status"};
                    if (m_axis_tdata[23:19] != 5'd0)       diff = {diff, " padding"};
                    if (diff != "")
                        report_mismatch($sformatf(
                            "bad%s: got tdata %h last %b user %b, want %h last %b user %b",
                            diff, m_axis_tdata, m_axis_tlast, m_axis_tuser,
                            {5'd0, want.status, want.mend, want.comp, want.ctrl,
                             want.opcode, want.data}, want.fend, want.valid));
                    if (want.status != ST_OK) rejects_seen++;
                    else if (want.valid)      payload_seen++;
                    else                      markers_seen++;
                end
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_COMPRESSION) comp_en = cfg_data[0];
                else                              max_len = cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                advance_parser(s_axis_tuser, s_axis_tdata, got, r);
                if (got) awaited_results.push_back(r);
            end
        end
        results_awaited = awaited_results.size();
    end

endmodule

### tb/sv/websocket_frame_receiver_tb.sv
`timescale 1ns / 1ps
// Top of the WebSocket frame receiver testbench: clock, reset, stimulus and verdict.
module websocket_frame_receiver_tb;
    import wsfr_pkg::*;

    localparam int         LENGTH_BITS   = 64;
    localparam logic       KIND_BYTE     = 1'b0;
    localparam logic       KIND_RESET    = 1'b1;
    localparam logic [3:0] OP_RSVD_DATA  = 4'h3;
    localparam logic [3:0] OP_RSVD_CTRL  = 4'hF;
    localparam int         ITEM_TARGET   = 1750;
    localparam int         CFG_EVERY     = 400;
    localparam int         HOLD_AT       = 500;
    localparam int         HOLD_CYCLES   = 300;
    localparam int         STEADY_FROM   = 900;
    localparam int         STEADY_TO     = 1200;
    localparam int         SETTLE_LIMIT  = 5000;
    localparam int         DRAIN_CYCLES  = 6;

    typedef enum logic [1:0] {
        FORM_SHORT,
        FORM_EXT16,
        FORM_EXT64
    } len_form_t;

    logic               clk           = 1'b0;
    logic               rst_n         = 1'b0;
    logic               cfg_valid     = 1'b0;
    logic               cfg_ready;
    cfg_index_t         cfg_index     = CFG_COMPRESSION;
    logic [31:0]        cfg_data      = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata  = '0;
    logic               s_axis_tuser  = 1'b0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [TDATA_W-1:0] m_axis_tdata;
    logic               m_axis_tlast;
    logic               m_axis_tuser;

    int failures;
    int results_awaited;
    int payload_seen;
    int markers_seen;
    int rejects_seen;

    // Stimulus bookkeeping
    int   sent_items   = 0;
    int   resets_sent  = 0;
    int   frames_sent  = 0;
    int   cfg_phases   = 0;
    logic steady       = 1'b0;
    logic hold_pending = 1'b1;
    logic gen_in_frag  = 1'b0;
    logic cur_comp     = 1'b0;
    logic [31:0] cur_max = 32'd16777216;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    websocket_frame_receiver #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    websocket_frame_receiver_checker #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tlast    (m_axis_tlast),
        .m_axis_tuser    (m_axis_tuser),
        .failures        (failures),
        .results_awaited (results_awaited),
        .payload_seen    (payload_seen),
        .markers_seen    (markers_seen),
        .rejects_seen    (rejects_seen)
    );

    // Offer one request; valid stays high on return so back-to-back requests need no gap
    task automatic send_req(input logic kind, input logic [7:0] b);
        while (!steady && $urandom_range(99) < 30) begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= b;
        do @(posedge clk); while (!s_axis_tready);
        sent_items++;
        steady = (sent_items >= STEADY_FROM && sent_items < STEADY_TO);
        @(negedge clk);
    endtask

    task automatic conn_reset();
        send_req(KIND_RESET, 8'($urandom_range(255)));
        gen_in_frag = 1'b0;
        resets_sent++;
    endtask

    // Header, extended length, mask key, then body_len payload bytes
    task automatic send_frame(input logic [7:0] b0, input logic [63:0] len,
                              input logic masked, input len_form_t form, input int body_len);
        send_req(KIND_BYTE, b0);
        case (form)
            FORM_EXT16: begin
                send_req(KIND_BYTE, {masked, LEN_EXT16});
                send_req(KIND_BYTE, len[15:8]);
                send_req(KIND_BYTE, len[7:0]);
            end
            FORM_EXT64: begin
                send_req(KIND_BYTE, {masked, LEN_EXT64});
                for (int i = 7; i >= 0; i--)
                    send_req(KIND_BYTE, len[8 * i +: 8]);
            end
            default: send_req(KIND_BYTE, {masked, len[6:0]});
        endcase
        if (masked)
            repeat (KEY_BYTES) send_req(KIND_BYTE, 8'($urandom_range(255)));
        repeat (body_len) send_req(KIND_BYTE, 8'($urandom_range(255)));
        frames_sent++;
    endtask

    // Park the stream and wait until every expected result has been taken or the limit runs out
    task automatic settle();
        int waited;
        waited = 0;
        s_axis_tvalid <= 1'b0;
        while (results_awaited != 0 && waited < SETTLE_LIMIT) begin
            @(negedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Write both registers; call only while the block is idle
    task automatic set_config(input logic comp, input logic [31:0] max_len);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_COMPRESSION;
        cfg_data  <= {31'd0, comp};
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_index <= CFG_MAX_LEN;
        cfg_data  <= max_len;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        cur_comp = comp;
        cur_max  = max_len;
        cfg_phases++;
    endtask

    function automatic logic [31:0] pick_max();
        case ($urandom_range(3))
            0:       return 32'($urandom_range(20));
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom;
            default: return 32'd16777216;
        endcase
    endfunction

    // One random frame: mostly well-formed, some with random headers, some just a connection reset
    task automatic random_frame();
        int          pick;
        logic        ctrl;
        logic        fin;
        logic        rsv1;
        logic        masked;
        logic [3:0]  op;
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [63:0] len;
        len_form_t   form;
        pick = $urandom_range(99);
        if (pick < 8) begin
            // random header, a few body bytes, then clear whatever it left behind
            b0 = 8'($urandom_range(255));
            b1 = 8'($urandom_range(255));
            if (b1[6:0] == LEN_EXT16) begin
                form = FORM_EXT16;
                len  = 64'($urandom_range(65535));
            end else if (b1[6:0] == LEN_EXT64) begin
                form = FORM_EXT64;
                len  = {$urandom, $urandom};
            end else begin
                form = FORM_SHORT;
                len  = 64'(b1[6:0]);
            end
            send_frame(b0, len, b1[7], form, $urandom_range(6));
            conn_reset();
            return;
        end
        if (pick < 11) begin
            conn_reset();
            return;
        end
        ctrl   = ($urandom_range(99) < (gen_in_frag ? 25 : 20));
        masked = ($urandom_range(3) != 0);
        fin    = ctrl ? 1'b1 : 1'($urandom_range(1));
        rsv1   = cur_comp & 1'($urandom_range(1));
        if (ctrl) begin
            case ($urandom_range(2))
                0:       op = OP_CLOSE;
                1:       op = OP_PING;
                default: op = OP_PONG;
            endcase
        end else if (gen_in_frag) begin
            op   = OP_CONT;
            rsv1 = 1'b0;
        end else begin
            op = $urandom_range(1) ? OP_TEXT : OP_BINARY;
        end
        pick = $urandom_range(99);
        if (pick < 70)                len = 64'($urandom_range(8));
        else if (pick < 95 || ctrl)   len = 64'($urandom_range(9, ctrl ? 125 : 40));
        else                          len = 64'($urandom_range(126, 300));
        pick = $urandom_range(99);
        if (len >= 126)     form = FORM_EXT16;
        else if (pick < 70) form = FORM_SHORT;
        else if (pick < 90) form = FORM_EXT16;
        else                form = FORM_EXT64;
        if (len > {32'd0, cur_max}) begin
            // rejected on length: send no body and clear the latched error
            send_frame({fin, rsv1, 2'b00, op}, len, masked, form, 0);
            conn_reset();
        end else begin
            send_frame({fin, rsv1, 2'b00, op}, len, masked, form, int'(len));
            if (!ctrl) gen_in_frag = !fin;
        end
    endtask

    // Receiver: random stalls, one long hold-off, and a stretch with none
    initial
    begin
        forever begin
            @(negedge clk);
            if (hold_pending && sent_items >= HOLD_AT) begin
                hold_pending = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end else begin
                m_axis_tready <= steady ? 1'b1 : ($urandom_range(99) >= 30);
            end
        end
    end

    // Run ends here if the block hangs
    initial
    begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        int next_cfg_at;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: every defined opcode, zero-length frames, all length forms, fragmentation
        send_frame({1'b1, 1'b0, 2'b00, OP_TEXT},   64'd0, 1'b0, FORM_SHORT, 0);
        send_frame({1'b1, 1'b0, 2'b00, OP_BINARY}, 64'd3, 1'b1, FORM_SHORT, 3);
        send_frame({1'b1, 1'b0, 2'b00, OP_PING},   64'd0, 1'b1, FORM_SHORT, 0);
        send_frame({1'b1, 1'b0, 2'b00, OP_PONG},   64'd2, 1'b0, FORM_EXT16, 2);
        send_frame({1'b1, 1'b0, 2'b00, OP_CLOSE},  64'd2, 1'b1, FORM_EXT64, 2);
        send_frame({1'b0, 1'b0, 2'b00, OP_TEXT},   64'd2, 1'b1, FORM_SHORT, 2);
        send_frame({1'b1, 1'b0, 2'b00, OP_PING},   64'd1, 1'b0, FORM_SHORT, 1);
        send_frame({1'b0, 1'b0, 2'b00, OP_CONT},   64'd0, 1'b0, FORM_SHORT, 0);
        send_frame({1'b1, 1'b0, 2'b00, OP_CONT},   64'd1, 1'b1, FORM_SHORT, 1);

        // Directed: every header error except RSV1 on a continuation, bytes ignored while latched, then clear
        send_frame({1'b1, 1'b0, 2'b10, OP_TEXT}, 64'd0, 1'b0, FORM_SHORT, 0);
        send_req(KIND_BYTE, 8'hFF);
        send_req(KIND_BYTE, 8'h00);
        conn_reset();
        send_frame({1'b1, 1'b1, 2'b01, OP_TEXT}, 64'd0, 1'b0, FORM_SHORT, 0);
        conn_reset();
        send_frame({1'b1, 1'b1, 2'b00, OP_TEXT}, 64'd0, 1'b0, FORM_SHORT, 0);
        conn_reset();
        send_frame({1'b1, 1'b0, 2'b00, OP_CONT}, 64'd0, 1'b1, FORM_SHORT, 0);
        conn_reset();
        send_frame({1'b0, 1'b0, 2'b00, OP_TEXT},   64'd0, 1'b0, FORM_SHORT, 0);
        send_frame({1'b1, 1'b0, 2'b00, OP_BINARY}, 64'd0, 1'b0, FORM_SHORT, 0);
        conn_reset();
        send_frame({1'b0, 1'b0, 2'b00, OP_PING}, 64'd0, 1'b0, FORM_SHORT, 0);
        conn_reset();
        send_frame({1'b1, 1'b0, 2'b00, OP_CLOSE}, 64'd126, 1'b1, FORM_EXT16, 0);
        conn_reset();
        send_frame({1'b1, 1'b0, 2'b00, OP_RSVD_DATA}, 64'd0, 1'b0, FORM_SHORT, 0);
        conn_reset();
        send_frame({1'b1, 1'b0, 2'b00, OP_RSVD_CTRL}, 64'd0, 1'b1, FORM_SHORT, 0);
        conn_reset();
        send_frame({1'b1, 1'b0, 2'b00, OP_BINARY}, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0,
                   FORM_EXT64, 0);
        conn_reset();

        // Compression on, zero length limit
        settle();
        set_config(1'b1, 32'd0);
        send_frame({1'b0, 1'b1, 2'b00, OP_TEXT}, 64'd0, 1'b1, FORM_SHORT, 0);
        send_frame({1'b1, 1'b1, 2'b00, OP_PING}, 64'd0, 1'b0, FORM_SHORT, 0);
        send_frame({1'b1, 1'b0, 2'b00, OP_CONT}, 64'd0, 1'b0, FORM_SHORT, 0);
        send_frame({1'b0, 1'b1, 2'b00, OP_BINARY}, 64'd0, 1'b0, FORM_SHORT, 0);
        send_frame({1'b1, 1'b1, 2'b00, OP_CONT},   64'd0, 1'b0, FORM_SHORT, 0);
        conn_reset();
        send_frame({1'b1, 1'b0, 2'b00, OP_BINARY}, 64'd1, 1'b0, FORM_SHORT, 0);
        conn_reset();

        // Compression off, largest length limit
        settle();
        set_config(1'b0, 32'hFFFF_FFFF);
        send_frame({1'b1, 1'b0, 2'b00, OP_BINARY}, 64'd2, 1'b1, FORM_EXT64, 2);
        send_frame({1'b1, 1'b0, 2'b00, OP_TEXT}, 64'h1_0000_0000, 1'b0, FORM_EXT64, 0);
        conn_reset();

        // Random traffic with a new setting now and then
        next_cfg_at = sent_items + CFG_EVERY;
        while (sent_items < ITEM_TARGET) begin
            if (sent_items >= next_cfg_at) begin
                settle();
                set_config(1'($urandom_range(1)), pick_max());
                next_cfg_at = sent_items + CFG_EVERY;
            end
            random_frame();
        end

        settle();
        $display("tb: sent %0d stream requests in %0d frames, %0d connection resets, %0d settings",
                 sent_items, frames_sent, resets_sent, cfg_phases);
        $display("tb: checked %0d payload bytes, %0d empty-frame markers, %0d header rejects",
                 payload_seen, markers_seen, rejects_seen);
        if (results_awaited != 0)
            $display("tb: %0d expected results never arrived", results_awaited);
        if (failures == 0 && results_awaited == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
